// ===== rtl/core/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

	// Parser phases
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_BODY   = 3'd1,
		PH_ESC    = 3'd2,
		PH_HEX1   = 3'd3,
		PH_WANTBS = 3'd4,
		PH_WANTU  = 3'd5,
		PH_HEX2   = 3'd6
	} jsu_phase_t;

	// Result kinds as seen on the output tuser
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} jsu_kind_t;

	// One queue entry: all results caused by one input byte
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		jsu_kind_t       kind;
	} jsu_entry_t;

	// Characters of interest
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// Surrogate ranges
	localparam logic [15:0] SUR_HI_MIN = 16'hD800;
	localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

endpackage

`default_nettype wire

// ===== rtl/core/jsu_front.sv =====
`default_nettype none

module jsu_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         data_byte,
	input  wire logic               start_req,
	output logic                    push,
	output jsu_pkg::jsu_entry_t     entry
);
	import jsu_pkg::*;

	jsu_phase_t  phase_q, phase_d;
	logic [1:0]  digit_q, digit_d;
	logic [15:0] first_q, first_d;
	logic [15:0] second_q, second_d;

	logic        hex_ok;
	logic [3:0]  hex_v;
	logic [15:0] unit1_nx;
	logic [15:0] unit2_nx;
	logic        unit1_hi;
	logic        unit1_lo;
	logic        unit2_lo;
	logic [20:0] pair_cp;

	function automatic jsu_entry_t one_entry(input logic [7:0] b, input jsu_kind_t k);
		jsu_entry_t e;
		e          = '0;
		e.bytes[0] = b;
		e.last_idx = 2'd0;
		e.kind     = k;
		return e;
	endfunction

	function automatic jsu_entry_t utf8_entry(input logic [20:0] cp);
		jsu_entry_t e;
		e      = '0;
		e.kind = KIND_DATA;
		if (cp <= 21'h7F) begin
			e.bytes[0] = cp[7:0];
			e.last_idx = 2'd0;
		end else if (cp <= 21'h7FF) begin
			e.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
			e.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
			e.last_idx = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			e.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
			e.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
			e.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
			e.last_idx = 2'd2;
		end else begin
			e.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
			e.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
			e.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
			e.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
			e.last_idx = 2'd3;
		end
		return e;
	endfunction

	// Decode one hex digit of either case
	always_comb begin
		hex_ok = 1'b1;
		hex_v  = 4'd0;
		if (data_byte inside {[8'h30:8'h39]}) begin
			hex_v = data_byte[3:0];
		end else if (data_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			hex_v = data_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	// Shift the digit into the unit being built
	assign unit1_nx = {first_q[11:0], hex_v};
	assign unit2_nx = {second_q[11:0], hex_v};
	assign unit1_hi = (unit1_nx >= SUR_HI_MIN) && (unit1_nx <= SUR_HI_MAX);
	assign unit1_lo = (unit1_nx >= SUR_LO_MIN) && (unit1_nx <= SUR_LO_MAX);
	assign unit2_lo = (unit2_nx >= SUR_LO_MIN) && (unit2_nx <= SUR_LO_MAX);
	assign pair_cp  = CP_SUPP_BASE + {1'b0, first_q[9:0], unit2_nx[9:0]};

	// Next state
	always_comb begin
		phase_d  = phase_q;
		digit_d  = digit_q;
		first_d  = first_q;
		second_d = second_q;
		if (accept) begin
			if (start_req) begin
				phase_d  = (data_byte == CH_QUOTE) ? PH_BODY : PH_IDLE;
				digit_d  = '0;
				first_d  = '0;
				second_d = '0;
			end else if (phase_q == PH_IDLE) begin
				phase_d = PH_IDLE;
			end else if (data_byte == CH_NUL) begin
				phase_d  = PH_IDLE;
				digit_d  = '0;
				first_d  = '0;
				second_d = '0;
			end else begin
				case (phase_q)
					PH_BODY: begin
						if (data_byte == CH_BSLASH) begin
							phase_d = PH_ESC;
						end else if (data_byte == CH_QUOTE) begin
							phase_d  = PH_IDLE;
							digit_d  = '0;
							first_d  = '0;
							second_d = '0;
						end
					end
					PH_ESC: begin
						if (data_byte == CH_U) begin
							phase_d = PH_HEX1;
							digit_d = '0;
							first_d = '0;
						end else if (data_byte inside {CH_QUOTE, CH_BSLASH, CH_SLASH,
								CH_B, CH_F, CH_N, CH_R, CH_T}) begin
							phase_d = PH_BODY;
						end else begin
							phase_d  = PH_IDLE;
							digit_d  = '0;
							first_d  = '0;
							second_d = '0;
						end
					end
					PH_HEX1: begin
						if (!hex_ok || (digit_q == 2'd3 && unit1_lo)) begin
							phase_d  = PH_IDLE;
							digit_d  = '0;
							first_d  = '0;
							second_d = '0;
						end else begin
							first_d = unit1_nx;
							digit_d = digit_q + 2'd1;
							if (digit_q == 2'd3) begin
								phase_d = unit1_hi ? PH_WANTBS : PH_BODY;
							end
						end
					end
					PH_WANTBS: begin
						if (data_byte == CH_BSLASH) begin
							phase_d = PH_WANTU;
						end else begin
							phase_d  = PH_IDLE;
							digit_d  = '0;
							first_d  = '0;
							second_d = '0;
						end
					end
					PH_WANTU: begin
						if (data_byte == CH_U) begin
							phase_d  = PH_HEX2;
							digit_d  = '0;
							second_d = '0;
						end else begin
							phase_d  = PH_IDLE;
							digit_d  = '0;
							first_d  = '0;
							second_d = '0;
						end
					end
					PH_HEX2: begin
						if (!hex_ok || (digit_q == 2'd3 && !unit2_lo)) begin
							phase_d  = PH_IDLE;
							digit_d  = '0;
							first_d  = '0;
							second_d = '0;
						end else begin
							second_d = unit2_nx;
							digit_d  = digit_q + 2'd1;
							if (digit_q == 2'd3) begin
								phase_d = PH_BODY;
							end
						end
					end
					default: begin
						phase_d  = PH_IDLE;
						digit_d  = '0;
						first_d  = '0;
						second_d = '0;
					end
				endcase
			end
		end
	end

	// Results for the current byte
	always_comb begin
		push  = 1'b0;
		entry = one_entry(8'h00, KIND_ERR);
		if (accept) begin
			if (start_req) begin
				push = (data_byte != CH_QUOTE);
			end else if (phase_q == PH_IDLE) begin
				push = 1'b0;
			end else if (data_byte == CH_NUL) begin
				push = 1'b1;
			end else begin
				case (phase_q)
					PH_BODY: begin
						if (data_byte == CH_QUOTE) begin
							push  = 1'b1;
							entry = one_entry(8'h00, KIND_DONE);
						end else if (data_byte != CH_BSLASH) begin
							push  = 1'b1;
							entry = one_entry(data_byte, KIND_DATA);
						end
					end
					PH_ESC: begin
						push = (data_byte != CH_U);
						case (data_byte)
							CH_QUOTE, CH_BSLASH, CH_SLASH:
								entry = one_entry(data_byte, KIND_DATA);
							CH_B: entry = one_entry(8'h08, KIND_DATA);
							CH_F: entry = one_entry(8'h0C, KIND_DATA);
							CH_N: entry = one_entry(8'h0A, KIND_DATA);
							CH_R: entry = one_entry(8'h0D, KIND_DATA);
							CH_T: entry = one_entry(8'h09, KIND_DATA);
							default: entry = one_entry(8'h00, KIND_ERR);
						endcase
					end
					PH_HEX1: begin
						if (!hex_ok) begin
							push = 1'b1;
						end else if (digit_q == 2'd3 && !unit1_hi) begin
							push = 1'b1;
							if (!unit1_lo) begin
								entry = utf8_entry({5'b00000, unit1_nx});
							end
						end
					end
					PH_WANTBS: push = (data_byte != CH_BSLASH);
					PH_WANTU:  push = (data_byte != CH_U);
					PH_HEX2: begin
						if (!hex_ok) begin
							push = 1'b1;
						end else if (digit_q == 2'd3) begin
							push = 1'b1;
							if (unit2_lo) begin
								entry = utf8_entry(pair_cp);
							end
						end
					end
					default: push = 1'b1;
				endcase
			end
		end
	end

	// Parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			digit_q  <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else begin
			phase_q  <= phase_d;
			digit_q  <= digit_d;
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_queue.sv =====
`default_nettype none

module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire jsu_pkg::jsu_entry_t push_entry,
	input  wire logic                pop,
	output jsu_pkg::jsu_entry_t      head,
	output logic                     empty,
	output logic                     full
);
	import jsu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	jsu_entry_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (AW+1)'(DEPTH));
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_back.sv =====
`default_nettype none

module jsu_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire jsu_pkg::jsu_entry_t head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,
	output logic [1:0]               m_tuser,
	output logic                     m_tlast
);
	import jsu_pkg::*;

	jsu_entry_t cur_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       xfer;
	logic       load;

	assign xfer     = m_tvalid && m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = cur_q.bytes[idx_q];
	assign m_tuser  = cur_q.kind;
	assign m_tlast  = (idx_q == cur_q.last_idx);
	assign load     = !valid_q || (xfer && m_tlast);
	assign pop      = load && !empty;

	// Hold the entry until its last byte is transferred
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Step through the bytes of the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			idx_q   <= '0;
		end else if (xfer) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/json_string_unescape_utf8.sv =====
// json_string_unescape_utf8
//
// Decodes one quoted JSON string, fed one character per transfer, into UTF-8.
// Input channel s_*: s_tdata is the character, s_tuser marks the opening quote
// of a new string. Output channel m_*: decoded bytes appear on m_tdata,
// m_tuser gives the kind (data, done, error), m_tlast marks the final result
// caused by one input character.
//
// The parser classifies a character in the cycle of its transfer and writes
// its results into the queue at that edge; once the output register is free,
// the output stage loads the first result into it for transfer.
// One character is taken per cycle as long as the result queue has room; a \u
// escape that completes a code point yields up to four output transfers, one
// per cycle while m_tready is high, and the queue between parser and output
// stage absorbs these bursts and receiver stalls. Sustained rate is one output
// transfer per cycle while m_tready is high, set by the output stage.
//
// Reset returns the parser to idle and empties the queue. While the receiver
// holds m_tready low, results stay in the output register and queue, and
// s_tready drops once the queue is full.
`default_nettype none

module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tuser,   // [0] start_req
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic [1:0]      m_tuser,   // [1:0] kind
	output logic            m_tlast
);
	import jsu_pkg::*;

	logic       accept;
	logic       fe_push;
	jsu_entry_t fe_entry;
	jsu_entry_t q_head;
	logic       q_empty;
	logic       q_full;
	logic       q_pop;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_tdata),
		.start_req (s_tuser),
		.push      (fe_push),
		.entry     (fe_entry)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fe_push),
		.push_entry (fe_entry),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	jsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Done and error results stand alone and carry a zero byte
	a_ctrl_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_DATA) |-> (m_tlast && m_tdata == 8'h00))
		else $error("done or error result not last or nonzero");

	// A start without an opening quote yields an error entry
	a_bad_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser && s_tdata != CH_QUOTE) |-> (fe_push && fe_entry.kind == KIND_ERR))
		else $error("bad start did not raise an error");

	// The parser never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fe_push |-> !q_full)
		else $error("push into full queue");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
import jsu_pkg::*;

// Marker returned for a byte that is not a hex digit
localparam logic [4:0] NOT_HEX = 5'h10;

typedef struct {
	logic [7:0] octet;
	jsu_kind_t  kind;
	logic       last_flag;
} unesc_result_t;

// Tracks the unescape state and the results still owed by the block
class unescape_tracker;
	jsu_phase_t    phase;
	logic [1:0]    digit_cnt;
	logic [15:0]   hi_unit;
	logic [15:0]   lo_unit;
	unesc_result_t owed[$];
	int            mismatches;

	function new();
		clear_state();
		mismatches = 0;
	endfunction

	function void clear_state();
		phase     = PH_IDLE;
		digit_cnt = 2'd0;
		hi_unit   = 16'h0000;
		lo_unit   = 16'h0000;
	endfunction

	function void push_result(logic [7:0] octet, jsu_kind_t kind);
		unesc_result_t r;
		r.octet     = octet;
		r.kind      = kind;
		r.last_flag = 1'b0;
		owed.push_back(r);
	endfunction

	function void raise_error();
		push_result(8'h00, KIND_ERR);
		clear_state();
	endfunction

	function logic [4:0] hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
		if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
		return NOT_HEX;
	endfunction

	// Encode one code point as one to four UTF-8 bytes
	function void emit_code_point(logic [20:0] cp);
		if (cp <= 21'h7F) begin
			push_result(cp[7:0], KIND_DATA);
		end else if (cp <= 21'h7FF) begin
			push_result({3'b110, cp[10:6]}, KIND_DATA);
			push_result({2'b10, cp[5:0]}, KIND_DATA);
		end else if (cp <= 21'hFFFF) begin
			push_result({4'b1110, cp[15:12]}, KIND_DATA);
			push_result({2'b10, cp[11:6]}, KIND_DATA);
			push_result({2'b10, cp[5:0]}, KIND_DATA);
		end else begin
			push_result({5'b11110, cp[20:18]}, KIND_DATA);
			push_result({2'b10, cp[17:12]}, KIND_DATA);
			push_result({2'b10, cp[11:6]}, KIND_DATA);
			push_result({2'b10, cp[5:0]}, KIND_DATA);
		end
	endfunction

	// Advance on one accepted character; returns 0 when the block ignores it
	function bit take_char(logic [7:0] c, logic start);
		int            n0;
		bit            used;
		logic [4:0]    nib;
		logic [15:0]   hi_off;
		logic [15:0]   lo_off;
		logic [20:0]   cp;
		unesc_result_t r;
		n0   = owed.size();
		used = 1'b1;
		if (start) begin
			clear_state();
			if (c == CH_QUOTE) phase = PH_BODY;
			else raise_error();
		end else if (phase == PH_IDLE) begin
			used = 1'b0;
		end else if (c == CH_NUL) begin
			raise_error();
		end else begin
			case (phase)
				PH_BODY: begin
					if (c == CH_BSLASH) begin
						phase = PH_ESC;
					end else if (c == CH_QUOTE) begin
						push_result(8'h00, KIND_DONE);
						clear_state();
					end else begin
						push_result(c, KIND_DATA);
					end
				end
				PH_ESC: begin
					phase = PH_BODY;
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: push_result(c, KIND_DATA);
						CH_B: push_result(8'h08, KIND_DATA);
						CH_F: push_result(8'h0C, KIND_DATA);
						CH_N: push_result(8'h0A, KIND_DATA);
						CH_R: push_result(8'h0D, KIND_DATA);
						CH_T: push_result(8'h09, KIND_DATA);
						CH_U: begin
							phase     = PH_HEX1;
							digit_cnt = 2'd0;
							hi_unit   = 16'h0000;
						end
						default: raise_error();
					endcase
				end
				PH_HEX1: begin
					nib = hex_nibble(c);
					if (nib == NOT_HEX) begin
						raise_error();
					end else begin
						hi_unit = {hi_unit[11:0], nib[3:0]};
						if (digit_cnt < 2'd3) begin
							digit_cnt++;
						end else begin
							digit_cnt = 2'd0;
							if (hi_unit >= SUR_HI_MIN && hi_unit <= SUR_HI_MAX) begin
								phase = PH_WANTBS;
							end else if (hi_unit >= SUR_LO_MIN && hi_unit <= SUR_LO_MAX) begin
								raise_error();
							end else begin
								emit_code_point({5'd0, hi_unit});
								phase = PH_BODY;
							end
						end
					end
				end
				PH_WANTBS: begin
					if (c == CH_BSLASH) phase = PH_WANTU;
					else raise_error();
				end
				PH_WANTU: begin
					if (c == CH_U) begin
						phase     = PH_HEX2;
						digit_cnt = 2'd0;
						lo_unit   = 16'h0000;
					end else begin
						raise_error();
					end
				end
				PH_HEX2: begin
					nib = hex_nibble(c);
					if (nib == NOT_HEX) begin
						raise_error();
					end else begin
						lo_unit = {lo_unit[11:0], nib[3:0]};
						if (digit_cnt < 2'd3) begin
							digit_cnt++;
						end else begin
							digit_cnt = 2'd0;
							if (lo_unit < SUR_LO_MIN || lo_unit > SUR_LO_MAX) begin
								raise_error();
							end else begin
								hi_off = hi_unit - SUR_HI_MIN;
								lo_off = lo_unit - SUR_LO_MIN;
								cp = CP_SUPP_BASE + {1'b0, hi_off[9:0], lo_off[9:0]};
								if (cp > 21'h10FFFF) begin
									raise_error();
								end else begin
									emit_code_point(cp);
									phase = PH_BODY;
								end
							end
						end
					end
				end
				default: raise_error();
			endcase
		end
		// Flag the final result caused by this character
		if (owed.size() > n0) begin
			r = owed.pop_back();
			r.last_flag = 1'b1;
			owed.push_back(r);
		end
		return used;
	endfunction

	// Compare one output transfer with the oldest owed result
	function void match_output(logic [7:0] octet, logic [1:0] kind, logic last_flag);
		unesc_result_t r;
		if (owed.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: data %02h kind %0d last %0d",
					octet, kind, last_flag);
			return;
		end
		r = owed.pop_front();
		if (octet !== r.octet || kind !== r.kind || last_flag !== r.last_flag) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: got data %02h kind %0d last %0d, ",
					octet, kind, last_flag,
					"expected data %02h kind %0d last %0d",
					r.octet, r.kind, r.last_flag);
		end
	endfunction

	function int pending();
		return owed.size();
	endfunction
endclass

module testbench;
	localparam int IDLE_LIMIT = 1000;
	localparam int LONG_HOLD  = 80;
	localparam int HEX_LOWER  = 0;
	localparam int HEX_UPPER  = 1;
	localparam int HEX_MIXED  = 2;
	localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
		CH_B, CH_F, CH_N, CH_R, CH_T};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] data_byte
	logic       s_tuser;   // [0] start_req
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic [1:0] m_tuser;   // [1:0] kind
	logic       m_tlast;

	bit              quiet;
	bit              long_hold_due;
	int              live_chars;
	int              base_chars;
	logic [8:0]      char_q[$];   // {start_req, data_byte}
	unescape_tracker tracker;

	json_string_unescape_utf8 u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none while quiet
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic logic [7:0] non_hex_char();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(8'h00, 8'h2F));
			1: return 8'($urandom_range(8'h3A, 8'h40));
			2: return 8'($urandom_range(8'h47, 8'h60));
			default: return 8'($urandom_range(8'h67, 8'hFF));
		endcase
	endfunction

	task automatic queue_char(input logic [7:0] c, input logic start);
		char_q.push_back({start, c});
	endtask

	task automatic queue_digits(input int count);
		repeat (count) queue_char(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
	endtask

	// Queue backslash, 'u' and four hex digits
	task automatic queue_u_escape(input logic [15:0] v, input int mode);
		logic [3:0] nib;
		bit         upper;
		queue_char(CH_BSLASH, 1'b0);
		queue_char(CH_U, 1'b0);
		for (int i = 3; i >= 0; i--) begin
			nib   = v[i*4 +: 4];
			upper = (mode == HEX_MIXED) ? bit'($urandom_range(0, 1)) : (mode == HEX_UPPER);
			if (nib < 4'd10)
				queue_char(8'("0") + 8'(nib), 1'b0);
			else
				queue_char((upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10, 1'b0);
		end
	endtask

	// Queue one string: mostly well formed, some broken or left open
	task automatic queue_string();
		int          n_elems;
		int          pick;
		logic [19:0] sup;
		logic [15:0] hi;
		if ($urandom_range(0, 19) == 0) queue_char(plain_char(), 1'b1);
		else queue_char(CH_QUOTE, 1'b1);
		n_elems = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
		for (int e = 0; e < n_elems; e++) begin
			pick = $urandom_range(0, 99);
			sup  = 20'($urandom_range(0, 20'hFFFFF));
			hi   = SUR_HI_MIN + {6'd0, sup[19:10]};
			if (pick < 35) begin
				queue_char(plain_char(), 1'b0);
			end else if (pick < 55) begin
				queue_char(CH_BSLASH, 1'b0);
				queue_char(ESC_LETTERS[$urandom_range(0, 7)], 1'b0);
			end else if (pick < 78) begin
				case ($urandom_range(0, 3))
					0: queue_u_escape(16'($urandom_range(0, 16'h7F)), HEX_MIXED);
					1: queue_u_escape(16'($urandom_range(16'h80, 16'h7FF)), HEX_MIXED);
					2: queue_u_escape(16'($urandom_range(16'h800, 16'hD7FF)), HEX_MIXED);
					default: queue_u_escape(16'($urandom_range(16'hE000, 16'hFFFF)), HEX_MIXED);
				endcase
			end else if (pick < 90) begin
				queue_u_escape(hi, HEX_MIXED);
				queue_u_escape(SUR_LO_MIN + {6'd0, sup[9:0]}, HEX_MIXED);
			end else begin
				case ($urandom_range(0, 7))
					0: queue_char(CH_NUL, 1'b0);
					1: begin
						queue_char(CH_BSLASH, 1'b0);
						queue_char(8'($urandom_range(0, 255)), 1'b0);
					end
					2: begin
						queue_char(CH_BSLASH, 1'b0);
						queue_char(CH_U, 1'b0);
						queue_digits($urandom_range(0, 3));
						queue_char(non_hex_char(), 1'b0);
					end
					3: queue_u_escape(16'($urandom_range(SUR_LO_MIN, SUR_LO_MAX)), HEX_MIXED);
					4: begin
						queue_u_escape(hi, HEX_MIXED);
						queue_char(plain_char(), 1'b0);
					end
					5: begin
						queue_u_escape(hi, HEX_MIXED);
						queue_char(CH_BSLASH, 1'b0);
						queue_char(8'($urandom_range(0, 255)), 1'b0);
					end
					6: begin
						queue_u_escape(hi, HEX_MIXED);
						if ($urandom_range(0, 1) == 0)
							queue_u_escape(16'($urandom_range(0, 16'hDBFF)), HEX_MIXED);
						else
							queue_u_escape(16'($urandom_range(16'hE000, 16'hFFFF)), HEX_MIXED);
					end
					default: begin
						queue_u_escape(hi, HEX_MIXED);
						queue_char(CH_BSLASH, 1'b0);
						queue_char(CH_U, 1'b0);
						queue_digits($urandom_range(0, 3));
						queue_char(non_hex_char(), 1'b0);
					end
				endcase
			end
		end
		// Close the string, close it and trail stray bytes, or leave it open
		pick = $urandom_range(0, 19);
		if (pick < 17) begin
			queue_char(CH_QUOTE, 1'b0);
		end else if (pick == 17) begin
			queue_char(CH_QUOTE, 1'b0);
			repeat ($urandom_range(1, 3)) queue_char(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// Drive queued characters; valid stays high between back-to-back transfers
	task automatic send_queued();
		logic [8:0] it;
		int         gap;
		while (char_q.size() > 0) begin
			it  = char_q.pop_front();
			gap = pick_gap();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= it[7:0];
			s_tuser  <= it[8];
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			void'(tracker.take_char(it[7:0], it[8]));
			live_chars++;
		end
	endtask

	task automatic run_until(input int goal);
		while (live_chars < goal) begin
			queue_string();
			send_queued();
		end
	endtask

	// Hold the sender until every owed result has come back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.pending() > 0);
	endtask

	// Receiver: check each output transfer, then pick the next ready value
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) tracker.match_output(m_tdata, m_tuser, m_tlast);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				stall_left    = LONG_HOLD;
			end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("FAIL json_string_unescape_utf8");
		$finish;
	end

	initial begin
		tracker       = new();
		quiet         = 1'b0;
		long_hold_due = 1'b0;
		live_chars    = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tuser  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start on a byte that is not a quote, then a stray byte while idle
		queue_char("x", 1'b1);
		queue_char("A", 1'b0);
		// Extreme plain bytes, a short escape, an escaped NUL code point
		queue_char(CH_QUOTE, 1'b1);
		queue_char(8'hFF, 1'b0);
		queue_char(8'h01, 1'b0);
		queue_char(CH_BSLASH, 1'b0);
		queue_char(CH_T, 1'b0);
		queue_u_escape(16'h0000, HEX_UPPER);
		// Highest code point from a surrogate pair, hex digits of both cases
		queue_u_escape(16'hDBFF, HEX_UPPER);
		queue_u_escape(16'hDFFF, HEX_LOWER);
		queue_char(CH_QUOTE, 1'b0);
		// NUL byte inside a string
		queue_char(CH_QUOTE, 1'b1);
		queue_char(CH_NUL, 1'b0);
		send_queued();
		wait_drain();

		// Random strings; partway through, the receiver holds off for a long stretch
		base_chars = live_chars;
		run_until(base_chars + 130);
		long_hold_due = 1'b1;
		run_until(base_chars + 205);
		wait_drain();
		// Back-to-back stretch with no idling on either side
		quiet = 1'b1;
		run_until(base_chars + 300);
		quiet = 1'b0;
		run_until(base_chars + 400);

		wait_drain();
		repeat (16) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("PASS json_string_unescape_utf8");
		else
			$display("FAIL json_string_unescape_utf8");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_utf8.sv
tb/testbench.sv
